// ----- rtl/core/rolling_hash_pattern_counter_macros.svh -----
// ----------------------------------------------------------------------------
// rolling hash pattern counter assertion macros
// shared assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_PATTERN_COUNTER_MACROS_SVH
`define ROLLING_HASH_PATTERN_COUNTER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define RHPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define RHPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define RHPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RHPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/rhpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhpc_pkg
// shared types and constants of the rolling hash pattern counter
// ----------------------------------------------------------------------------
package rhpc_pkg;

	localparam int MAX_PATTERN_DEF = 64;

	// input command codes
	localparam logic [1:0] CMD_PATTERN = 2'd0;
	localparam logic [1:0] CMD_TEXT    = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	// classified operation kinds
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_TEXT   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// modular unit operations
	localparam logic ARITH_RED = 1'b0;
	localparam logic ARITH_MUL = 1'b1;

	// register index
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MOD  = 1'b1;

	localparam logic [15:0] BASE_RST = 16'd256;
	localparam logic [30:0] MOD_RST  = 31'd1000000007;
	localparam logic [30:0] MOD_MIN  = 31'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} op_t;

	typedef struct packed {
		logic        window_full;
		logic        hash_equal;
		logic        match_found;
		logic [31:0] occurrence_count;
		logic        text_done;
	} result_t;

	typedef struct packed {
		logic [15:0] base;
		logic [30:0] modulus;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic        op;
		logic [31:0] a;
		logic [30:0] x;
	} arith_req_t;

endpackage

// ----- rtl/core/rhpc_ram.sv -----
// ----------------------------------------------------------------------------
// rhpc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rhpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/rhpc_fifo.sv -----
// ----------------------------------------------------------------------------
// rhpc_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module rhpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/core/rhpc_modarith.sv -----
// ----------------------------------------------------------------------------
// rhpc_modarith
// bit-serial modular unit: reduce a 32-bit value, or multiply a 16-bit
// factor by a reduced operand, one bit per cycle
// ----------------------------------------------------------------------------
module rhpc_modarith (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rhpc_pkg::arith_req_t  req,
	input  logic [30:0]           modulus,
	output logic                  done,
	output logic [30:0]           result
);

	logic        busy_q;
	logic        done_q;
	logic        op_q;
	logic [5:0]  cnt_q;
	logic [31:0] sh_q;
	logic [30:0] x_q;
	logic [30:0] acc_q;

	logic [31:0] mod_ext;
	logic [31:0] red_t;
	logic [31:0] red_n;
	logic [31:0] dbl;
	logic [31:0] dbl_n;
	logic [31:0] add_t;
	logic [31:0] add_n;
	logic [30:0] step_res;

	always_comb begin
		mod_ext = {1'b0, modulus};
		// reduce: shift in the next dividend bit
		red_t   = {acc_q, sh_q[31]};
		red_n   = (red_t >= mod_ext) ? red_t - mod_ext : red_t;
		// multiply: double, then add the operand when the factor bit is set
		dbl     = {acc_q, 1'b0};
		dbl_n   = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
		add_t   = dbl_n + (sh_q[15] ? {1'b0, x_q} : 32'd0);
		add_n   = (add_t >= mod_ext) ? add_t - mod_ext : add_t;
		step_res = (op_q == rhpc_pkg::ARITH_MUL) ? add_n[30:0] : red_n[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == rhpc_pkg::ARITH_MUL) ? 6'd15 : 6'd31;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			sh_q  <= req.a;
			x_q   <= req.x;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= step_res;
			sh_q  <= {sh_q[30:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

// ----- rtl/core/rhpc_front.sv -----
// ----------------------------------------------------------------------------
// rhpc_front
// accepts requests, classifies the command and queues them for the back end
// ----------------------------------------------------------------------------
module rhpc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      command,
	input  logic [7:0]      byte_value,
	input  logic            end_of_text,
	output logic            op_valid,
	output rhpc_pkg::op_t   op,
	input  logic            op_take
);

	rhpc_pkg::op_t in_op;
	logic          q_empty;

	always_comb begin
		in_op.data = byte_value;
		in_op.last = 1'b0;
		case (command)
			rhpc_pkg::CMD_PATTERN: in_op.kind = rhpc_pkg::OP_APPEND;
			rhpc_pkg::CMD_TEXT: begin
				in_op.kind = rhpc_pkg::OP_TEXT;
				// end mark only matters on text
				in_op.last = end_of_text;
			end
			rhpc_pkg::CMD_CLEAR:   in_op.kind = rhpc_pkg::OP_CLEAR;
			default:               in_op.kind = rhpc_pkg::OP_NONE;
		endcase
	end

	rhpc_fifo #(
		.WIDTH ($bits(rhpc_pkg::op_t)),
		.DEPTH (2)
	) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_op),
		.full   (full),
		.pop    (op_take),
		.rdata  (op),
		.empty  (q_empty)
	);

	assign op_valid = !q_empty;

endmodule

// ----- rtl/core/rhpc_back.sv -----
// ----------------------------------------------------------------------------
// rhpc_back
// sequencer that updates pattern and window hashes through the shared
// modular unit and verifies hash hits byte by byte
// ----------------------------------------------------------------------------
`include "rolling_hash_pattern_counter_macros.svh"

module rhpc_back #(
	parameter int MAX_PATTERN = rhpc_pkg::MAX_PATTERN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rhpc_pkg::cfg_t      cfg,
	input  logic                op_valid,
	input  rhpc_pkg::op_t       op,
	output logic                op_take,
	input  logic                res_full,
	output logic                res_push,
	output rhpc_pkg::result_t   res
);

	localparam int IW = MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1;
	localparam int LW = $clog2(MAX_PATTERN + 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_PH_RED  = 4'd1;
	localparam logic [3:0] ST_PH_MUL  = 4'd2;
	localparam logic [3:0] ST_PH_ADD  = 4'd3;
	localparam logic [3:0] ST_W_RED   = 4'd4;
	localparam logic [3:0] ST_W_MUL   = 4'd5;
	localparam logic [3:0] ST_H_RED   = 4'd6;
	localparam logic [3:0] ST_W2_RED  = 4'd7;
	localparam logic [3:0] ST_SUB_MUL = 4'd8;
	localparam logic [3:0] ST_T_MUL   = 4'd9;
	localparam logic [3:0] ST_T_ADD   = 4'd10;
	localparam logic [3:0] ST_P_RED   = 4'd11;
	localparam logic [3:0] ST_V_RD    = 4'd12;
	localparam logic [3:0] ST_V_CMP   = 4'd13;
	localparam logic [3:0] ST_OUT     = 4'd14;

	logic [3:0]           state_q;
	logic [LW-1:0]        len_q;
	logic [LW-1:0]        fill_q;
	logic [IW-1:0]        head_q;
	logic [30:0]          ph_q;
	logic [30:0]          w_q;
	logic [30:0]          wh_q;
	logic [31:0]          total_q;
	logic [LW-1:0]        j_q;
	logic                 prefill_q;
	logic                 full_q;
	logic                 heq_q;
	logic                 found_q;
	logic                 done_q;
	rhpc_pkg::op_t        op_q;
	logic [30:0]          h_q;
	logic [IW-1:0]        waddr_q;
	rhpc_pkg::arith_req_t req_q;

	logic                 ar_done;
	logic [30:0]          ar_res;
	logic [31:0]          mod_ext;
	logic [31:0]          t_sum;
	logic [31:0]          t_red;
	logic                 dispatch;
	logic                 slide;
	logic [IW-1:0]        vaddr;
	logic                 pat_we;
	logic                 win_we;
	logic                 win_re;
	logic                 pat_re;
	logic [IW-1:0]        win_raddr;
	logic [7:0]           win_rdata;
	logic [7:0]           pat_rdata;

	function automatic logic [IW-1:0] wrap_idx(input logic [LW:0] s);
		logic [LW:0] lim;
		lim = (LW + 1)'(MAX_PATTERN);
		if (s >= lim) begin
			return IW'(s - lim);
		end
		return IW'(s);
	endfunction

	always_comb begin
		mod_ext   = {1'b0, cfg.modulus};
		// h and sub are both below the modulus, so one subtract settles t
		t_sum     = {1'b0, h_q} + mod_ext - {1'b0, ar_res};
		t_red     = (t_sum >= mod_ext) ? t_sum - mod_ext : t_sum;
		dispatch  = (state_q == ST_IDLE) && op_valid && !res_full;
		slide     = (fill_q == len_q);
		vaddr     = wrap_idx((LW + 1)'(head_q) + (LW + 1)'(j_q));
		pat_we    = dispatch && (op.kind == rhpc_pkg::OP_APPEND)
		            && (len_q < LW'(MAX_PATTERN));
		win_we    = (state_q == ST_T_ADD) && ar_done;
		win_re    = (dispatch && (op.kind == rhpc_pkg::OP_TEXT) && (len_q != '0) && slide)
		            || (state_q == ST_V_RD);
		pat_re    = (state_q == ST_V_RD);
		win_raddr = (state_q == ST_IDLE) ? head_q : vaddr;
	end

	assign op_take  = dispatch;
	assign res_push = (state_q == ST_OUT);

	always_comb begin
		res.window_full      = full_q;
		res.hash_equal       = heq_q;
		res.match_found      = found_q;
		res.occurrence_count = total_q;
		res.text_done        = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			fill_q      <= '0;
			head_q      <= '0;
			ph_q        <= '0;
			w_q         <= 31'd1;
			wh_q        <= '0;
			total_q     <= '0;
			j_q         <= '0;
			prefill_q   <= 1'b0;
			full_q      <= 1'b0;
			heq_q       <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
			waddr_q     <= '0;
			req_q       <= '0;
		end else begin
			req_q.start <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (dispatch) begin
						full_q  <= 1'b0;
						heq_q   <= 1'b0;
						found_q <= 1'b0;
						done_q  <= op.last;
						case (op.kind)
							rhpc_pkg::OP_APPEND: begin
								fill_q  <= '0;
								head_q  <= '0;
								wh_q    <= '0;
								total_q <= '0;
								if (len_q < LW'(MAX_PATTERN)) begin
									req_q <= '{1'b1, rhpc_pkg::ARITH_RED, {1'b0, ph_q}, 31'd0};
									state_q <= ST_PH_RED;
								end else begin
									state_q <= ST_OUT;
								end
							end
							rhpc_pkg::OP_CLEAR: begin
								len_q   <= '0;
								ph_q    <= '0;
								w_q     <= 31'd1;
								fill_q  <= '0;
								head_q  <= '0;
								wh_q    <= '0;
								total_q <= '0;
								state_q <= ST_OUT;
							end
							rhpc_pkg::OP_TEXT: begin
								if (len_q == '0) begin
									state_q <= ST_OUT;
								end else begin
									prefill_q <= !slide;
									waddr_q   <= wrap_idx((LW + 1)'(head_q)
									             + (LW + 1)'(slide ? len_q : fill_q));
									req_q <= '{1'b1, rhpc_pkg::ARITH_RED, {1'b0, wh_q}, 31'd0};
									state_q <= ST_H_RED;
								end
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_PH_RED: if (ar_done) begin
					req_q <= '{1'b1, rhpc_pkg::ARITH_MUL, {16'd0, cfg.base}, ar_res};
					state_q <= ST_PH_MUL;
				end
				ST_PH_MUL: if (ar_done) begin
					req_q <= '{1'b1, rhpc_pkg::ARITH_RED,
					           {1'b0, ar_res} + {24'd0, op_q.data}, 31'd0};
					state_q <= ST_PH_ADD;
				end
				ST_PH_ADD: if (ar_done) begin
					ph_q <= ar_res;
					if (len_q != '0) begin
						req_q <= '{1'b1, rhpc_pkg::ARITH_RED, {1'b0, w_q}, 31'd0};
						state_q <= ST_W_RED;
					end else begin
						len_q   <= len_q + 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_W_RED: if (ar_done) begin
					req_q <= '{1'b1, rhpc_pkg::ARITH_MUL, {16'd0, cfg.base}, ar_res};
					state_q <= ST_W_MUL;
				end
				ST_W_MUL: if (ar_done) begin
					w_q     <= ar_res;
					len_q   <= len_q + 1'b1;
					state_q <= ST_OUT;
				end
				ST_H_RED: if (ar_done) begin
					if (prefill_q) begin
						req_q <= '{1'b1, rhpc_pkg::ARITH_MUL, {16'd0, cfg.base}, ar_res};
						state_q <= ST_T_MUL;
					end else begin
						req_q <= '{1'b1, rhpc_pkg::ARITH_RED, {1'b0, w_q}, 31'd0};
						state_q <= ST_W2_RED;
					end
				end
				ST_W2_RED: if (ar_done) begin
					// leading byte times the weight
					req_q <= '{1'b1, rhpc_pkg::ARITH_MUL, {24'd0, win_rdata}, ar_res};
					state_q <= ST_SUB_MUL;
				end
				ST_SUB_MUL: if (ar_done) begin
					req_q <= '{1'b1, rhpc_pkg::ARITH_MUL, {16'd0, cfg.base}, t_red[30:0]};
					state_q <= ST_T_MUL;
				end
				ST_T_MUL: if (ar_done) begin
					req_q <= '{1'b1, rhpc_pkg::ARITH_RED,
					           {1'b0, ar_res} + {24'd0, op_q.data}, 31'd0};
					state_q <= ST_T_ADD;
				end
				ST_T_ADD: if (ar_done) begin
					wh_q <= ar_res;
					if (prefill_q) begin
						fill_q <= fill_q + 1'b1;
					end else begin
						head_q <= wrap_idx((LW + 1)'(head_q) + (LW + 1)'(1));
					end
					if (!prefill_q || (fill_q + 1'b1 == len_q)) begin
						full_q <= 1'b1;
						req_q <= '{1'b1, rhpc_pkg::ARITH_RED, {1'b0, ph_q}, 31'd0};
						state_q <= ST_P_RED;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_P_RED: if (ar_done) begin
					if (ar_res == wh_q) begin
						heq_q   <= 1'b1;
						j_q     <= '0;
						state_q <= ST_V_RD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_V_RD: state_q <= ST_V_CMP;
				ST_V_CMP: begin
					if (win_rdata != pat_rdata) begin
						state_q <= ST_OUT;
					end else if (j_q + 1'b1 == len_q) begin
						found_q <= 1'b1;
						if (total_q != '1) begin
							total_q <= total_q + 1'b1;
						end
						state_q <= ST_OUT;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_V_RD;
					end
				end
				ST_OUT: begin
					// last text byte closes the text
					if (done_q) begin
						fill_q  <= '0;
						head_q  <= '0;
						wh_q    <= '0;
						total_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and reduced window hash, no reset
	always_ff @(posedge clk) begin
		if (dispatch) begin
			op_q <= op;
		end
		if ((state_q == ST_H_RED) && ar_done) begin
			h_q <= ar_res;
		end
	end

	rhpc_modarith u_arith (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_q),
		.modulus (cfg.modulus),
		.done    (ar_done),
		.result  (ar_res)
	);

	rhpc_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PATTERN)
	) u_pattern_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (IW'(len_q)),
		.wdata (op.data),
		.re    (pat_re),
		.raddr (IW'(j_q)),
		.rdata (pat_rdata)
	);

	rhpc_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PATTERN)
	) u_window_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (waddr_q),
		.wdata (op_q.data),
		.re    (win_re),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	`RHPC_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, fill_q <= len_q)
	`RHPC_ASSERT_IMPL(a_head_bound, clk, arst_n, 1'b1, (LW + 1)'(head_q) < (LW + 1)'(MAX_PATTERN))
	`RHPC_ASSERT_IMPL(a_start_busy, clk, arst_n, req_q.start, state_q != ST_IDLE && state_q != ST_OUT)
	`RHPC_ASSERT_NEXT(a_out_idle, clk, arst_n, state_q == ST_OUT, state_q == ST_IDLE)

endmodule

// ----- rtl/core/rolling_hash_pattern_counter.sv -----
// ----------------------------------------------------------------------------
// rolling_hash_pattern_counter
// rabin-karp matcher counting pattern occurrences in a byte stream
// ----------------------------------------------------------------------------
// Requests enter through push/full: command 0 appends a pattern byte, 1 feeds
// a text byte (end_of_text marks the last one), 2 clears pattern and text.
// Every request gives exactly one result on the empty/pop side, in order.
// The front queues up to two requests; the back handles one at a time through
// a bit-serial modular unit. Clear, an unused code or text with no pattern go
// straight to the result; a pattern byte or text byte takes a series of
// reductions and multiplies, more for a later pattern byte and for a text byte
// that fills or slides the window, and a hash hit is then verified byte by
// byte against the pattern memory. The back takes a new request only once the
// current one has given its result, so the modular unit sets the throughput.
// Registers hash_base (0x0) and hash_modulus (0x4) are written over the APB
// port; the user must write them only while the block is idle, which the
// block itself does not enforce. A modulus below two acts as two.
// Reset empties both queues, clears pattern and text state and loads the
// register defaults. A stalled receiver fills the two-entry result queue,
// after which the back stops taking requests and full rises once the front
// queue is full too.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_counter #(
	parameter int MAX_PATTERN = rhpc_pkg::MAX_PATTERN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [7:0]  byte_value,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic        window_full,
	output logic        hash_equal,
	output logic        match_found,
	output logic [31:0] occurrence_count,
	output logic        text_done
);

	logic [15:0]         base_q;
	logic [30:0]         mod_q;
	rhpc_pkg::cfg_t      cfg;
	logic                op_valid;
	rhpc_pkg::op_t       op;
	logic                op_take;
	logic                res_full;
	logic                res_push;
	rhpc_pkg::result_t   res_in;
	rhpc_pkg::result_t   res_out;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= rhpc_pkg::BASE_RST;
			mod_q  <= rhpc_pkg::MOD_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				rhpc_pkg::REG_BASE: base_q <= pwdata[15:0];
				rhpc_pkg::REG_MOD:  mod_q  <= pwdata[30:0];
				default:            base_q <= base_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rhpc_pkg::REG_BASE: prdata = {16'd0, base_q};
			rhpc_pkg::REG_MOD:  prdata = {1'b0, mod_q};
			default:            prdata = '0;
		endcase
	end

	always_comb begin
		cfg.base    = base_q;
		cfg.modulus = (mod_q < rhpc_pkg::MOD_MIN) ? rhpc_pkg::MOD_MIN : mod_q;
	end

	rhpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.byte_value  (byte_value),
		.end_of_text (end_of_text),
		.op_valid    (op_valid),
		.op          (op),
		.op_take     (op_take)
	);

	rhpc_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	rhpc_fifo #(
		.WIDTH ($bits(rhpc_pkg::result_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign window_full      = res_out.window_full;
	assign hash_equal       = res_out.hash_equal;
	assign match_found      = res_out.match_found;
	assign occurrence_count = res_out.occurrence_count;
	assign text_done        = res_out.text_done;

endmodule

// ----- test/rolling_hash_pattern_counter_test.sv -----
// ----------------------------------------------------------------------------
// rolling_hash_pattern_counter_test
// drives pattern, text, clear and unused requests and register writes under
// random gaps and stalls, predicts every result with an independent rabin-karp
// counter and checks each field
class occurrence_checker;
	localparam int DEPTH = rhpc_pkg::MAX_PATTERN_DEF;

	logic [15:0]       base;
	logic [30:0]       modulus;
	logic [7:0]        pat_bytes[DEPTH];
	int                pat_len;
	longint unsigned   pat_sig;
	longint unsigned   lead_weight;
	logic [7:0]        win_bytes[DEPTH];
	int                win_head;
	int                win_fill;
	longint unsigned   win_hash;
	logic [31:0]       hit_total;
	rhpc_pkg::result_t pending_results[$];
	int                mismatches;

	function new();
		base = rhpc_pkg::BASE_RST;
		modulus = rhpc_pkg::MOD_RST;
		pat_len = 0;
		pat_sig = 0;
		lead_weight = 1;
		mismatches = 0;
		restart_text();
	endfunction

	function void restart_text();
		win_head = 0;
		win_fill = 0;
		win_hash = 0;
		hit_total = 0;
	endfunction

	function void note_request(logic [1:0] cmd, logic [7:0] b, logic last);
		longint unsigned m, h, sub, t;
		rhpc_pkg::result_t r;
		int j;
		m = (modulus < rhpc_pkg::MOD_MIN) ? 2 : modulus;
		r = '0;
		case (cmd)
			rhpc_pkg::CMD_PATTERN: begin
				if (pat_len < DEPTH) begin
					pat_bytes[pat_len] = b;
					pat_sig = (base * (pat_sig % m) + b) % m;
					if (pat_len >= 1)
						lead_weight = (base * (lead_weight % m)) % m;
					pat_len++;
				end
				restart_text();
			end
			rhpc_pkg::CMD_CLEAR: begin
				pat_len = 0;
				pat_sig = 0;
				lead_weight = 1;
				restart_text();
			end
			rhpc_pkg::CMD_TEXT: begin
				if (pat_len > 0) begin
					h = win_hash % m;
					if (win_fill < pat_len) begin
						win_bytes[(win_head + win_fill) % DEPTH] = b;
						win_hash = (base * h + b) % m;
						win_fill++;
					end else begin
						sub = (win_bytes[win_head % DEPTH] * (lead_weight % m)) % m;
						t = (h + m - sub) % m;
						win_bytes[(win_head + pat_len) % DEPTH] = b;
						win_head = (win_head + 1) % DEPTH;
						win_hash = (base * t + b) % m;
					end
					if (win_fill == pat_len) begin
						r.window_full = 1'b1;
						if (win_hash % m == pat_sig % m) begin
							r.hash_equal = 1'b1;
							for (j = 0; j < pat_len; j++)
								if (win_bytes[(win_head + j) % DEPTH] != pat_bytes[j]) break;
							if (j == pat_len) begin
								r.match_found = 1'b1;
								if (hit_total != 32'hFFFF_FFFF) hit_total++;
							end
						end
					end
				end
				r.text_done = last;
			end
			default: ;
		endcase
		r.occurrence_count = hit_total;
		pending_results.push_back(r);
		if (r.text_done) restart_text();
	endfunction

	function void check_result(rhpc_pkg::result_t got);
		rhpc_pkg::result_t exp;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %p", got);
			return;
		end
		exp = pending_results.pop_front();
		if (got !== exp) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected %p, got %p", exp, got);
		end
	endfunction
endclass

module rolling_hash_pattern_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_BASE = 3'd0;
	localparam logic [2:0] ADDR_MOD  = 3'd4;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int ITEM_TARGET = 1900;
	localparam int SETTLE = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0, full;
	logic [1:0]  command = rhpc_pkg::CMD_PATTERN;
	logic [7:0]  byte_value = '0;
	logic        end_of_text = 1'b0;
	logic        empty, pop = 1'b0;
	logic        window_full, hash_equal, match_found, text_done;
	logic [31:0] occurrence_count;

	occurrence_checker checker_h = new();
	int  sent = 0;
	int  cycles = 0;
	bit  push_busy = 1'b0;
	bit  pop_busy = 1'b0;

	rolling_hash_pattern_counter u_top (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) checker_h.note_request(command, byte_value, end_of_text);
			if (pop && !empty)
				checker_h.check_result({window_full, hash_equal, match_found,
					occurrence_count, text_done});
		end
	end

	// result side: random stalls, with bursts of no stalling
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = pop_busy ? 0 : $urandom_range(0, 19);
			if ($urandom_range(0, 49) == 0) pop_busy = ~pop_busy;
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	task automatic send(logic [1:0] cmd, logic [7:0] b, logic last);
		int gap;
		gap = push_busy ? 0 : $urandom_range(0, 19);
		if ($urandom_range(0, 59) == 0) push_busy = ~push_busy;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		byte_value <= b;
		end_of_text <= last;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (checker_h.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_BASE) checker_h.base = value[15:0];
		else checker_h.modulus = value[30:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one pattern followed by text salted with copies of it
	task automatic run_sequence();
		logic [7:0] alphabet[4];
		logic [7:0] pat[$];
		int len, text_len, k, n;
		bit wide, broken;
		for (k = 0; k < 4; k++) alphabet[k] = 8'($urandom);
		n = $urandom_range(1, 4);
		wide = ($urandom_range(0, 4) == 0);
		len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 6);
		send(rhpc_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
		pat = {};
		for (k = 0; k < len; k++) begin
			pat.push_back(wide ? 8'($urandom) : alphabet[$urandom_range(0, n - 1)]);
			send(rhpc_pkg::CMD_PATTERN, pat[k], 1'($urandom));
		end
		text_len = $urandom_range(0, (len > 8) ? 80 : 3 * len + 8);
		broken = ($urandom_range(0, 9) == 0);
		k = 0;
		while (k < text_len) begin
			if ($urandom_range(0, 9) < 4 && k + pat.size() <= text_len && pat.size() <= 8) begin
				foreach (pat[i]) send(rhpc_pkg::CMD_TEXT, pat[i], 1'b0);
				k += pat.size();
			end else begin
				send(rhpc_pkg::CMD_TEXT,
					wide ? 8'($urandom) : alphabet[$urandom_range(0, n - 1)], 1'b0);
				k++;
			end
			if (broken && $urandom_range(0, 15) == 0)
				send(rhpc_pkg::CMD_PATTERN, 8'($urandom), 1'b0);
		end
		send(rhpc_pkg::CMD_TEXT, 8'($urandom), broken ? 1'b0 : 1'b1);
	endtask

	initial begin
		logic [15:0] bases[6];
		logic [30:0] mods[6];
		int ph, quota;
		bases = '{16'd256, 16'd1, 16'd65535, 16'd3, 16'd2, 16'd31};
		mods = '{31'd1000000007, 31'd2, 31'h7FFF_FFFF, 31'd0, 31'd1, 31'd101};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pattern, unused code, byte extremes, restart cases
		send(rhpc_pkg::CMD_TEXT, 8'hAA, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'h55, 1'b1);
		send(CMD_UNUSED, 8'hFF, 1'b1);
		send(rhpc_pkg::CMD_PATTERN, 8'h00, 1'b1);
		send(rhpc_pkg::CMD_PATTERN, 8'hFF, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'h00, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'hFF, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'h00, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'hFF, 1'b0);
		send(rhpc_pkg::CMD_PATTERN, 8'h00, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'h00, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'h00, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'h00, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'h00, 1'b1);
		send(rhpc_pkg::CMD_TEXT, 8'h00, 1'b0);
		send(rhpc_pkg::CMD_CLEAR, 8'hFF, 1'b1);
		send(rhpc_pkg::CMD_TEXT, 8'hFF, 1'b1);
		send(rhpc_pkg::CMD_PATTERN, 8'h80, 1'b0);
		send(rhpc_pkg::CMD_TEXT, 8'h80, 1'b1);

		quota = ITEM_TARGET / 7;
		for (ph = 0; ph < 7; ph++) begin
			if (ph > 0) begin
				drain();
				if (ph < 6) begin
					write_reg(ADDR_BASE, {16'd0, bases[ph]});
					write_reg(ADDR_MOD, {1'b0, mods[ph]});
				end else begin
					write_reg(ADDR_BASE, {16'd0, 16'($urandom_range(1, 65535))});
					write_reg(ADDR_MOD, {1'b0, 31'($urandom)});
				end
			end
			while (sent < quota * (ph + 1)) begin
				if ($urandom_range(0, 9) == 0)
					send(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
				else
					run_sequence();
			end
		end

		drain();
		if (checker_h.mismatches == 0 && checker_h.pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- rolling_hash_pattern_counter.f -----
+incdir+rtl/core
rtl/core/rhpc_pkg.sv
rtl/core/rhpc_ram.sv
rtl/core/rhpc_fifo.sv
rtl/core/rhpc_modarith.sv
rtl/core/rhpc_front.sv
rtl/core/rhpc_back.sv
rtl/core/rolling_hash_pattern_counter.sv
test/rolling_hash_pattern_counter_test.sv
